// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, active during reset as well
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label failed");

// clocked property, switched off while the active-low reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: label failed");

`endif

// File: src/sqjn_pkg.sv
// shared types, character codes and helpers for the quote normalizer
// no dependencies
`default_nettype none

package sqjn_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one to two result bytes produced by one request
  typedef struct packed {
    logic       two;
    logic       last;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } bundle_t;

  function automatic logic word_char(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

// File: src/sqjn_front.sv
// front end: string state tracking and per-request rewrite decision
// depends on sqjn_pkg
`default_nettype none

module sqjn_front import sqjn_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t in_item,
  output logic          q_push,
  output bundle_t       q_data
);

  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] before_r, before_nxt;
  logic       ins_r, ins_nxt;
  logic       ind_r, ind_nxt;

  logic [7:0] b;
  logic       lst;
  logic       cons;
  logic [1:0] cnt;
  logic [7:0] o0, o1;
  logic       ins_mid, ind_mid;
  logic [7:0] before_mid;
  logic [7:0] tail;

  always_comb begin
    b       = in_item.in_byte;
    lst     = in_item.in_last;
    cons    = 1'b0;
    cnt     = 2'd0;
    o0      = CH_NUL;
    o1      = CH_NUL;
    ins_mid = ins_r;
    ind_mid = ind_r;

    // held byte, with the incoming byte as its successor
    if (held_valid_r) begin
      cnt = 2'd1;
      if (held_r == CH_BSLASH) begin
        if (ins_r && (b == CH_BSLASH || b == CH_SQUOTE)) begin
          o0   = b;
          cons = 1'b1;
        end else if (ins_r || ind_r) begin
          o0   = held_r;
          o1   = b;
          cnt  = 2'd2;
          cons = 1'b1;
        end else begin
          o0 = held_r;
        end
      end else if (held_r == CH_SQUOTE && !ind_r) begin
        // apostrophe between word characters inside a single-quoted string stays
        if (ins_r && word_char(before_r) && word_char(b)) begin
          o0 = CH_SQUOTE;
        end else begin
          ins_mid = !ins_r;
          o0      = CH_DQUOTE;
        end
      end else if (held_r == CH_DQUOTE && !ins_r) begin
        ind_mid = !ind_r;
        o0      = CH_DQUOTE;
      end else begin
        o0 = held_r;
      end
    end

    before_mid = held_valid_r ? (cons ? b : held_r) : before_r;

    // final byte has no successor, so only the quote swap can apply
    tail = (b == CH_SQUOTE && !ind_mid) ? CH_DQUOTE : b;
    if (lst && !cons) begin
      if (cnt == 2'd0) begin
        o0  = tail;
        cnt = 2'd1;
      end else begin
        o1  = tail;
        cnt = 2'd2;
      end
    end

    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    before_nxt     = before_r;
    ins_nxt        = ins_r;
    ind_nxt        = ind_r;
    if (accept) begin
      if (lst) begin
        held_nxt       = CH_NUL;
        held_valid_nxt = 1'b0;
        before_nxt     = CH_NUL;
        ins_nxt        = 1'b0;
        ind_nxt        = 1'b0;
      end else begin
        held_nxt       = cons ? held_r : b;
        held_valid_nxt = !cons;
        before_nxt     = before_mid;
        ins_nxt        = ins_mid;
        ind_nxt        = ind_mid;
      end
    end

    q_push       = accept && (cnt != 2'd0);
    q_data.two   = (cnt == 2'd2);
    q_data.last  = lst;
    q_data.byte0 = o0;
    q_data.byte1 = o1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= CH_NUL;
      held_valid_r <= 1'b0;
      before_r     <= CH_NUL;
      ins_r        <= 1'b0;
      ind_r        <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      before_r     <= before_nxt;
      ins_r        <= ins_nxt;
      ind_r        <= ind_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/sqjn_queue.sv
// small queue of result bundles between front and back end
// depends on sqjn_pkg
`default_nettype none

module sqjn_queue import sqjn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr_en,
  input  wire bundle_t wr_data,
  output logic         full,
  input  wire logic    rd_en,
  output bundle_t      rd_data,
  output logic         nempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign nempty  = (cnt_r != '0);
  assign rd_data = mem[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && nempty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: src/sqjn_back.sv
// back end: splits each bundle into single result bytes behind a register
// depends on sqjn_pkg
`default_nettype none

module sqjn_back import sqjn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire bundle_t q_data,
  output logic         q_pop,
  input  wire logic    pop,
  output logic         empty,
  output out_item_t    out_item
);

  bundle_t bnd_r, bnd_nxt;
  logic    bvalid_r, bvalid_nxt;
  logic    sel_r, sel_nxt;
  logic    final_byte;
  logic    done;
  logic    load;

  assign final_byte = !bnd_r.two || sel_r;
  assign done       = bvalid_r && pop && final_byte;
  assign load       = q_valid && (!bvalid_r || done);
  assign q_pop      = load;

  assign empty             = !bvalid_r;
  assign out_item.out_byte = sel_r ? bnd_r.byte1 : bnd_r.byte0;
  assign out_item.out_last = bnd_r.last && final_byte;

  always_comb begin
    bnd_nxt    = bnd_r;
    bvalid_nxt = bvalid_r;
    sel_nxt    = sel_r;
    if (load) begin
      bnd_nxt    = q_data;
      bvalid_nxt = 1'b1;
      sel_nxt    = 1'b0;
    end else if (done) begin
      bvalid_nxt = 1'b0;
      sel_nxt    = 1'b0;
    end else if (bvalid_r && pop) begin
      // first of two bytes taken
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      bvalid_r <= bvalid_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bnd_r <= bnd_nxt;
  end

endmodule

`default_nettype wire

// File: src/single_quote_json_normalizer_unit.sv
// top level of the quote normalizer: front end, bundle queue, back end
// depends on sqjn_pkg, sqjn_front, sqjn_queue, sqjn_back
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------
//   input    | push / full      | in_item  (in_byte, in_last)
//   result   | pop / empty      | out_item (out_byte, out_last)
//
// one request is taken per cycle while the bundle queue has room; the front
// end decides in the cycle of acceptance and writes up to two bytes as one bundle
// results leave at one byte per cycle from the back end register while pop is
// high, so a request that yields two bytes holds the result side until both go
// a bundle written into the queue moves on into the back end register when the
// back end is free; the first byte of a text is held until its successor
// arrives, so it leaves with the next request; reset clears the control state
// full rises only when the queue of QUEUE_DEPTH bundles fills under stalls
`default_nettype none

module single_quote_json_normalizer_unit import sqjn_pkg::*; #(
  parameter int QUEUE_DEPTH = sqjn_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  logic    accept;
  logic    q_push;
  bundle_t q_wdata;
  logic    q_full;
  logic    q_pop;
  bundle_t q_rdata;
  logic    q_nempty;

  assign full   = q_full;
  assign accept = push && !q_full;

  sqjn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  sqjn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .nempty  (q_nempty)
  );

  sqjn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_nempty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// File: src/sqjn_checker.sv
// port-level checks for the quote normalizer, bound to the top level
// depends on sqjn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sqjn_checker import sqjn_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      push,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item
);

  // reset leaves nothing to deliver
  `ASSERT_CLK(a_reset_empty, clk, !rst_n |=> empty)

  // with the back end idle the queue is never full
  `ASSERT_RST(a_idle_not_full, clk, rst_n, empty |-> !full)

  // the queue only fills on a request
  `ASSERT_RST(a_full_by_push, clk, rst_n, $rose(full) |-> $past(push))

  // a waiting result holds until taken
  `ASSERT_RST(a_out_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_item)))

endmodule

bind single_quote_json_normalizer_unit sqjn_checker u_sqjn_checker (.*);

`default_nettype wire
